// ----- hdl/mpevd_pkg.sv -----
// ----------------------------------------------------------------------------
// mpevd_pkg
// Shared widths, register indexes and bundle types of the edge velocity damper.
// ----------------------------------------------------------------------------
package mpevd_pkg;

    localparam int INDEX_BITS_DEF = 16;
    localparam int DATA_W         = 32;
    localparam int RAD_W          = 31;
    localparam int CNT_W          = 17;
    localparam int SQ_W           = 2 * RAD_W;
    localparam int MAG_W          = 64;
    localparam int QUO_W          = 32;
    localparam int DEN_W          = 68;
    localparam int NUM_W          = 98;
    localparam int IDX_W          = 3;

    typedef enum logic [IDX_W-1:0] {
        REG_OUTER_RADIUS  = 3'd0,
        REG_FIRST_RADIUS  = 3'd1,
        REG_FIRST_CX      = 3'd2,
        REG_FIRST_CY      = 3'd3,
        REG_SECOND_RADIUS = 3'd4,
        REG_SECOND_CX     = 3'd5,
        REG_SECOND_CY     = 3'd6,
        REG_SPECIAL_COUNT = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic [SQ_W-1:0]          outer_sq;
        logic [SQ_W-1:0]          r1_sq;
        logic [SQ_W-1:0]          r2_sq;
        logic signed [DATA_W-1:0] c1x;
        logic signed [DATA_W-1:0] c1y;
        logic signed [DATA_W-1:0] c2x;
        logic signed [DATA_W-1:0] c2y;
        logic [CNT_W-1:0]         special;
    } t_cfg;

    typedef struct packed {
        logic                     held;
        logic                     dec;
        logic                     nz;
        logic                     flip_x;
        logic                     flip_y;
        logic signed [DATA_W-1:0] vx;
        logic signed [DATA_W-1:0] vy;
        logic signed [DATA_W-1:0] bx;
        logic signed [DATA_W-1:0] by;
    } t_side;

    typedef struct packed {
        logic [DEN_W-1:0] rem;
        logic [QUO_W-1:0] low;
        logic [QUO_W-1:0] quo;
    } t_lane;

endpackage

// ----- hdl/mesh_point_edge_velocity_damper.sv -----
// ----------------------------------------------------------------------------
// mesh_point_edge_velocity_damper
// Per-point velocity choice with radial damping at the mesh edges.
// ----------------------------------------------------------------------------
// Takes one mesh point per clock while s_axis_tready is high and returns one
// velocity word per point, in order. A point passes 41 registers: 4 geometry
// stages, 3 numerator stages, a 32-stage quotient pipeline that yields one bit
// per stage, a final subtract and saturate stage and the output word. One word
// can wait in the output register without the input stopping; once a second
// word waits in the spare register, s_axis_tready drops until the output word
// is taken. Configuration writes are to be made while idle, which the block
// itself does not enforce; so made, they apply to points accepted after the
// write edge.
module mesh_point_edge_velocity_damper import mpevd_pkg::*; #(
    parameter int  INDEX_BITS = INDEX_BITS_DEF,
    localparam int IN_W       = ((INDEX_BITS + 6 * DATA_W + 7) / 8) * 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [IDX_W-1:0]  i_cfg_index,
    input  logic [DATA_W-1:0] i_cfg_data,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    // point_index, mesh_x, mesh_y, cell_vx, cell_vy, base_vx, base_vy, zero pad
    input  logic [IN_W-1:0]   s_axis_tdata,
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    // out_vx, out_vy
    output logic [2*DATA_W-1:0] m_axis_tdata,
    // damped
    output logic [0:0]        m_axis_tuser
);

    t_cfg             w_cfg;
    logic             w_en;
    logic             w_g_valid, w_n_valid, w_d_valid;
    logic [MAG_W-1:0] w_sm;
    logic [DATA_W-1:0] w_mx, w_my, w_vx, w_vy;
    logic [DEN_W-1:0] w_g_den, w_n_den;
    logic [NUM_W-1:0] w_nx, w_ny;
    logic [QUO_W-1:0] w_qx, w_qy;
    t_side            w_g_side, w_n_side, w_d_side;
    logic             w_damped;

    mpevd_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    mpevd_geom #(.INDEX_BITS(INDEX_BITS)) u_geom (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (s_axis_tvalid),
        .i_index (s_axis_tdata[INDEX_BITS-1:0]),
        .i_x     ($signed(s_axis_tdata[INDEX_BITS +: DATA_W])),
        .i_y     ($signed(s_axis_tdata[INDEX_BITS + DATA_W +: DATA_W])),
        .i_vx    ($signed(s_axis_tdata[INDEX_BITS + 2*DATA_W +: DATA_W])),
        .i_vy    ($signed(s_axis_tdata[INDEX_BITS + 3*DATA_W +: DATA_W])),
        .i_bx    ($signed(s_axis_tdata[INDEX_BITS + 4*DATA_W +: DATA_W])),
        .i_by    ($signed(s_axis_tdata[INDEX_BITS + 5*DATA_W +: DATA_W])),
        .i_cfg   (w_cfg),
        .o_valid (w_g_valid),
        .o_sm    (w_sm),
        .o_mx    (w_mx),
        .o_my    (w_my),
        .o_den   (w_g_den),
        .o_side  (w_g_side)
    );

    mpevd_numer u_numer (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_g_valid),
        .i_sm    (w_sm),
        .i_mx    (w_mx),
        .i_my    (w_my),
        .i_den   (w_g_den),
        .i_side  (w_g_side),
        .o_valid (w_n_valid),
        .o_nx    (w_nx),
        .o_ny    (w_ny),
        .o_den   (w_n_den),
        .o_side  (w_n_side)
    );

    mpevd_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_n_valid),
        .i_nx    (w_nx),
        .i_ny    (w_ny),
        .i_den   (w_n_den),
        .i_side  (w_n_side),
        .o_valid (w_d_valid),
        .o_qx    (w_qx),
        .o_qy    (w_qy),
        .o_side  (w_d_side)
    );

    mpevd_out u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_d_valid),
        .i_qx     (w_qx),
        .i_qy     (w_qy),
        .i_side   (w_d_side),
        .i_ready  (m_axis_tready),
        .o_en     (w_en),
        .o_valid  (m_axis_tvalid),
        .o_vx     (w_vx),
        .o_vy     (w_vy),
        .o_damped (w_damped)
    );

    assign s_axis_tready = w_en;
    assign m_axis_tdata  = {w_vy, w_vx};
    assign m_axis_tuser  = w_damped;

endmodule

// ----- hdl/mpevd_cfg.sv -----
// ----------------------------------------------------------------------------
// mpevd_cfg
// Configuration registers with registered squares of the three radii.
// ----------------------------------------------------------------------------
module mpevd_cfg import mpevd_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [IDX_W-1:0]  i_cfg_index,
    input  logic [DATA_W-1:0] i_cfg_data,
    output t_cfg              o_cfg
);

    logic [RAD_W-1:0]         r_outer;
    logic [RAD_W-1:0]         r_r1;
    logic [RAD_W-1:0]         r_r2;
    logic signed [DATA_W-1:0] r_c1x;
    logic signed [DATA_W-1:0] r_c1y;
    logic signed [DATA_W-1:0] r_c2x;
    logic signed [DATA_W-1:0] r_c2y;
    logic [CNT_W-1:0]         r_special;
    logic [SQ_W-1:0]          r_outer_sq;
    logic [SQ_W-1:0]          r_r1_sq;
    logic [SQ_W-1:0]          r_r2_sq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_outer    <= '0;
            r_r1       <= '0;
            r_r2       <= '0;
            r_c1x      <= '0;
            r_c1y      <= '0;
            r_c2x      <= '0;
            r_c2y      <= '0;
            r_special  <= '0;
            r_outer_sq <= '0;
            r_r1_sq    <= '0;
            r_r2_sq    <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (t_reg_idx'(i_cfg_index))
                    REG_OUTER_RADIUS:  r_outer   <= i_cfg_data[RAD_W-1:0];
                    REG_FIRST_RADIUS:  r_r1      <= i_cfg_data[RAD_W-1:0];
                    REG_FIRST_CX:      r_c1x     <= $signed(i_cfg_data);
                    REG_FIRST_CY:      r_c1y     <= $signed(i_cfg_data);
                    REG_SECOND_RADIUS: r_r2      <= i_cfg_data[RAD_W-1:0];
                    REG_SECOND_CX:     r_c2x     <= $signed(i_cfg_data);
                    REG_SECOND_CY:     r_c2y     <= $signed(i_cfg_data);
                    REG_SPECIAL_COUNT: r_special <= i_cfg_data[CNT_W-1:0];
                    default:           r_special <= r_special;
                endcase
            end
            // squares are registered from the radii, so they follow in the cycle after a write
            r_outer_sq <= r_outer * r_outer;
            r_r1_sq    <= r_r1 * r_r1;
            r_r2_sq    <= r_r2 * r_r2;
        end
    end

    always_comb begin
        o_cfg.outer_sq = r_outer_sq;
        o_cfg.r1_sq    = r_r1_sq;
        o_cfg.r2_sq    = r_r2_sq;
        o_cfg.c1x      = r_c1x;
        o_cfg.c1y      = r_c1y;
        o_cfg.c2x      = r_c2x;
        o_cfg.c2y      = r_c2y;
        o_cfg.special  = r_special;
    end

endmodule

// ----- hdl/mpevd_geom.sv -----
// ----------------------------------------------------------------------------
// mpevd_geom
// Four stages: offsets, products, distance and dot tests, damping decision.
// ----------------------------------------------------------------------------
module mpevd_geom import mpevd_pkg::*; #(
    parameter int INDEX_BITS = INDEX_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  logic                     i_valid,
    input  logic [INDEX_BITS-1:0]    i_index,
    input  logic signed [DATA_W-1:0] i_x,
    input  logic signed [DATA_W-1:0] i_y,
    input  logic signed [DATA_W-1:0] i_vx,
    input  logic signed [DATA_W-1:0] i_vy,
    input  logic signed [DATA_W-1:0] i_bx,
    input  logic signed [DATA_W-1:0] i_by,
    input  t_cfg                     i_cfg,
    output logic                     o_valid,
    output logic [MAG_W-1:0]         o_sm,
    output logic [DATA_W-1:0]        o_mx,
    output logic [DATA_W-1:0]        o_my,
    output logic [DEN_W-1:0]         o_den,
    output t_side                    o_side
);

    localparam int CMP_W = (INDEX_BITS > CNT_W) ? INDEX_BITS : CNT_W;

    // stage 1
    logic                     r1_valid, r1_held;
    logic signed [DATA_W-1:0] r1_x, r1_y, r1_vx, r1_vy, r1_bx, r1_by;
    logic signed [DATA_W:0]   r1_dx1, r1_dy1, r1_dx2, r1_dy2;
    // stage 2
    logic                     r2_valid, r2_held;
    logic signed [DATA_W-1:0] r2_x, r2_y, r2_vx, r2_vy, r2_bx, r2_by;
    logic signed [63:0]       r2_xx, r2_yy, r2_p0x, r2_p0y;
    logic signed [65:0]       r2_a1, r2_b1, r2_a2, r2_b2;
    logic signed [64:0]       r2_p1x, r2_p1y, r2_p2x, r2_p2y;
    // stage 3
    logic                     r3_valid, r3_held, r3_far, r3_in1, r3_in2;
    logic                     r3_d1_neg, r3_d2_neg;
    logic signed [DATA_W-1:0] r3_x, r3_y, r3_vx, r3_vy, r3_bx, r3_by;
    logic [63:0]              r3_n;
    logic signed [64:0]       r3_s0;
    // stage 4
    logic                     r4_valid;
    logic [MAG_W-1:0]         r4_sm;
    logic [DATA_W-1:0]        r4_mx, r4_my;
    logic [DEN_W-1:0]         r4_den;
    t_side                    r4_side;

    logic [63:0]        c3_n;
    logic [66:0]        c3_q1, c3_q2;
    logic signed [65:0] c3_d1, c3_d2;
    logic signed [64:0] c3_s0;
    logic               c4_s0_pos, c4_dec;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
            r4_valid <= 1'b0;
        end else if (i_en) begin
            r1_valid <= i_valid;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
            r4_valid <= r3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_held <= CMP_W'(i_index) < CMP_W'(i_cfg.special);
            r1_x    <= i_x;
            r1_y    <= i_y;
            r1_vx   <= i_vx;
            r1_vy   <= i_vy;
            r1_bx   <= i_bx;
            r1_by   <= i_by;
            r1_dx1  <= (DATA_W+1)'(i_x) - (DATA_W+1)'(i_cfg.c1x);
            r1_dy1  <= (DATA_W+1)'(i_y) - (DATA_W+1)'(i_cfg.c1y);
            r1_dx2  <= (DATA_W+1)'(i_x) - (DATA_W+1)'(i_cfg.c2x);
            r1_dy2  <= (DATA_W+1)'(i_y) - (DATA_W+1)'(i_cfg.c2y);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_held <= r1_held;
            r2_x    <= r1_x;
            r2_y    <= r1_y;
            r2_vx   <= r1_vx;
            r2_vy   <= r1_vy;
            r2_bx   <= r1_bx;
            r2_by   <= r1_by;
            r2_xx   <= r1_x * r1_x;
            r2_yy   <= r1_y * r1_y;
            r2_p0x  <= r1_x * r1_vx;
            r2_p0y  <= r1_y * r1_vy;
            r2_a1   <= r1_dx1 * r1_dx1;
            r2_b1   <= r1_dy1 * r1_dy1;
            r2_a2   <= r1_dx2 * r1_dx2;
            r2_b2   <= r1_dy2 * r1_dy2;
            r2_p1x  <= r1_dx1 * r1_vx;
            r2_p1y  <= r1_dy1 * r1_vy;
            r2_p2x  <= r1_dx2 * r1_vx;
            r2_p2y  <= r1_dy2 * r1_vy;
        end
    end

    always_comb begin
        c3_n  = $unsigned(r2_xx) + $unsigned(r2_yy);
        c3_q1 = 67'($unsigned(r2_a1)) + 67'($unsigned(r2_b1));
        c3_q2 = 67'($unsigned(r2_a2)) + 67'($unsigned(r2_b2));
        c3_s0 = 65'(r2_p0x) + 65'(r2_p0y);
        c3_d1 = 66'(r2_p1x) + 66'(r2_p1y);
        c3_d2 = 66'(r2_p2x) + 66'(r2_p2y);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_held   <= r2_held;
            r3_x      <= r2_x;
            r3_y      <= r2_y;
            r3_vx     <= r2_vx;
            r3_vy     <= r2_vy;
            r3_bx     <= r2_bx;
            r3_by     <= r2_by;
            r3_n      <= c3_n;
            r3_s0     <= c3_s0;
            r3_far    <= c3_n > 64'(i_cfg.outer_sq);
            r3_in1    <= c3_q1 < 67'(i_cfg.r1_sq);
            r3_in2    <= c3_q2 < 67'(i_cfg.r2_sq);
            r3_d1_neg <= c3_d1[65];
            r3_d2_neg <= c3_d2[65];
        end
    end

    // held points first, then the outer test, then the first circle, then the second
    always_comb begin
        c4_s0_pos = !r3_s0[64] && (r3_s0 != '0);
        priority if (r3_held) c4_dec = 1'b0;
        else if (r3_far)      c4_dec = c4_s0_pos;
        else if (r3_in1)      c4_dec = r3_d1_neg;
        else if (r3_in2)      c4_dec = r3_d2_neg;
        else                  c4_dec = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r4_sm          <= r3_s0[64] ? MAG_W'(-r3_s0) : MAG_W'(r3_s0);
            r4_mx          <= r3_x[DATA_W-1] ? (~$unsigned(r3_x) + 1'b1) : $unsigned(r3_x);
            r4_my          <= r3_y[DATA_W-1] ? (~$unsigned(r3_y) + 1'b1) : $unsigned(r3_y);
            r4_den         <= DEN_W'({r3_n, 3'b000}) + DEN_W'({r3_n, 1'b0});
            r4_side.held   <= r3_held;
            r4_side.dec    <= c4_dec;
            r4_side.nz     <= r3_n != '0;
            r4_side.flip_x <= r3_s0[64] ^ r3_x[DATA_W-1];
            r4_side.flip_y <= r3_s0[64] ^ r3_y[DATA_W-1];
            r4_side.vx     <= r3_vx;
            r4_side.vy     <= r3_vy;
            r4_side.bx     <= r3_bx;
            r4_side.by     <= r3_by;
        end
    end

    assign o_valid = r4_valid;
    assign o_sm    = r4_sm;
    assign o_mx    = r4_mx;
    assign o_my    = r4_my;
    assign o_den   = r4_den;
    assign o_side  = r4_side;

endmodule

// ----- hdl/mpevd_numer.sv -----
// ----------------------------------------------------------------------------
// mpevd_numer
// Three stages forming 9 * |p.v| * |x| and 9 * |p.v| * |y| from 32-bit products.
// ----------------------------------------------------------------------------
module mpevd_numer import mpevd_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [MAG_W-1:0]  i_sm,
    input  logic [DATA_W-1:0] i_mx,
    input  logic [DATA_W-1:0] i_my,
    input  logic [DEN_W-1:0]  i_den,
    input  t_side             i_side,
    output logic              o_valid,
    output logic [NUM_W-1:0]  o_nx,
    output logic [NUM_W-1:0]  o_ny,
    output logic [DEN_W-1:0]  o_den,
    output t_side             o_side
);

    logic [2:0]       r_valid;
    logic [63:0]      r5_xl, r5_xh, r5_yl, r5_yh;
    logic [95:0]      r6_px, r6_py;
    logic [NUM_W-1:0] r7_nx, r7_ny;
    logic [DEN_W-1:0] r5_den, r6_den, r7_den;
    t_side            r5_side, r6_side, r7_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_en) begin
            r_valid <= {r_valid[1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r5_xl   <= i_sm[31:0] * i_mx;
            r5_xh   <= i_sm[63:32] * i_mx;
            r5_yl   <= i_sm[31:0] * i_my;
            r5_yh   <= i_sm[63:32] * i_my;
            r5_den  <= i_den;
            r5_side <= i_side;
            r6_px   <= {r5_xh, 32'd0} + 96'(r5_xl);
            r6_py   <= {r5_yh, 32'd0} + 96'(r5_yl);
            r6_den  <= r5_den;
            r6_side <= r5_side;
            r7_nx   <= NUM_W'(99'({r6_px, 3'b000}) + 99'(r6_px));
            r7_ny   <= NUM_W'(99'({r6_py, 3'b000}) + 99'(r6_py));
            r7_den  <= r6_den;
            r7_side <= r6_side;
        end
    end

    assign o_valid = r_valid[2];
    assign o_nx    = r7_nx;
    assign o_ny    = r7_ny;
    assign o_den   = r7_den;
    assign o_side  = r7_side;

endmodule

// ----- hdl/mpevd_div.sv -----
// ----------------------------------------------------------------------------
// mpevd_div
// Pipelined restoring divider, one quotient bit per stage, two lanes.
// ----------------------------------------------------------------------------
module mpevd_div import mpevd_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [NUM_W-1:0]  i_nx,
    input  logic [NUM_W-1:0]  i_ny,
    input  logic [DEN_W-1:0]  i_den,
    input  t_side             i_side,
    output logic              o_valid,
    output logic [QUO_W-1:0]  o_qx,
    output logic [QUO_W-1:0]  o_qy,
    output t_side             o_side
);

    function automatic t_lane div_step(input t_lane a, input logic [DEN_W-1:0] d);
        logic [DEN_W:0] t;
        t_lane          r;
        t     = {a.rem, a.low[QUO_W-1]};
        r.low = {a.low[QUO_W-2:0], 1'b0};
        if (t >= {1'b0, d}) begin
            r.rem = DEN_W'(t - {1'b0, d});
            r.quo = {a.quo[QUO_W-2:0], 1'b1};
        end else begin
            r.rem = t[DEN_W-1:0];
            r.quo = {a.quo[QUO_W-2:0], 1'b0};
        end
        return r;
    endfunction

    logic [QUO_W-1:0] r_valid;
    t_lane            r_lx   [QUO_W];
    t_lane            r_ly   [QUO_W];
    logic [DEN_W-1:0] r_den  [QUO_W];
    t_side            r_side [QUO_W];
    t_lane            c_x0, c_y0;

    // quotient stays below 2^32, so the top bits already sit below the divisor
    always_comb begin
        c_x0.rem = DEN_W'(i_nx[NUM_W-1:QUO_W]);
        c_x0.low = i_nx[QUO_W-1:0];
        c_x0.quo = '0;
        c_y0.rem = DEN_W'(i_ny[NUM_W-1:QUO_W]);
        c_y0.low = i_ny[QUO_W-1:0];
        c_y0.quo = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_en) begin
            r_valid <= {r_valid[QUO_W-2:0], i_valid};
        end
    end

    genvar k;
    for (k = 0; k < QUO_W; k++) begin : g_step
        if (k == 0) begin : g_first
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_lx[k]   <= div_step(c_x0, i_den);
                    r_ly[k]   <= div_step(c_y0, i_den);
                    r_den[k]  <= i_den;
                    r_side[k] <= i_side;
                end
            end
        end else begin : g_next
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_lx[k]   <= div_step(r_lx[k-1], r_den[k-1]);
                    r_ly[k]   <= div_step(r_ly[k-1], r_den[k-1]);
                    r_den[k]  <= r_den[k-1];
                    r_side[k] <= r_side[k-1];
                end
            end
        end
    end

    assign o_valid = r_valid[QUO_W-1];
    assign o_qx    = r_lx[QUO_W-1].quo;
    assign o_qy    = r_ly[QUO_W-1].quo;
    assign o_side  = r_side[QUO_W-1];

endmodule

// ----- hdl/mpevd_out.sv -----
// ----------------------------------------------------------------------------
// mpevd_out
// Final subtract and saturate, result select, and a two-word output skid.
// ----------------------------------------------------------------------------
module mpevd_out import mpevd_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [QUO_W-1:0]  i_qx,
    input  logic [QUO_W-1:0]  i_qy,
    input  t_side             i_side,
    input  logic              i_ready,
    output logic              o_en,
    output logic              o_valid,
    output logic [DATA_W-1:0] o_vx,
    output logic [DATA_W-1:0] o_vy,
    output logic              o_damped
);

    typedef struct packed {
        logic [DATA_W-1:0] vx;
        logic [DATA_W-1:0] vy;
        logic              damped;
    } t_res;

    localparam logic signed [34:0] SAT_MAX = 35'sd2147483647;
    localparam logic signed [34:0] SAT_MIN = -35'sd2147483648;

    function automatic logic [DATA_W-1:0] sat(input logic signed [34:0] v);
        logic [DATA_W-1:0] r;
        if (v > SAT_MAX)      r = SAT_MAX[DATA_W-1:0];
        else if (v < SAT_MIN) r = SAT_MIN[DATA_W-1:0];
        else                  r = v[DATA_W-1:0];
        return r;
    endfunction

    logic               r_f_valid, r_h_valid, r_s_valid;
    t_res               r_f, r_h, r_s;
    logic               n_h_valid, n_s_valid;
    t_res               n_h, n_s, c_res;
    logic signed [34:0] c_cx, c_cy;
    logic               c_en, c_push, c_pop;

    always_comb begin
        c_cx = i_side.flip_x ? -35'(i_qx) : 35'(i_qx);
        c_cy = i_side.flip_y ? -35'(i_qy) : 35'(i_qy);
        priority if (i_side.held) begin
            c_res.vx = '0;
            c_res.vy = '0;
        end else if (i_side.dec && i_side.nz) begin
            c_res.vx = sat(35'(i_side.vx) - c_cx);
            c_res.vy = sat(35'(i_side.vy) - c_cy);
        end else if (i_side.dec) begin
            // point at the origin keeps the cell velocity
            c_res.vx = i_side.vx;
            c_res.vy = i_side.vy;
        end else begin
            c_res.vx = i_side.bx;
            c_res.vy = i_side.by;
        end
        c_res.damped = i_side.dec;
    end

    // pipeline moves while the spare word is free
    assign c_en   = !r_s_valid;
    assign c_push = c_en && r_f_valid;
    assign c_pop  = r_h_valid && i_ready;

    always_comb begin
        n_h       = r_h;
        n_s       = r_s;
        n_h_valid = r_h_valid;
        n_s_valid = r_s_valid;
        if (c_pop) begin
            n_h       = r_s;
            n_h_valid = r_s_valid;
            n_s_valid = 1'b0;
        end
        if (c_push) begin
            if (!n_h_valid) begin
                n_h       = r_f;
                n_h_valid = 1'b1;
            end else begin
                n_s       = r_f;
                n_s_valid = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_valid <= 1'b0;
            r_h_valid <= 1'b0;
            r_s_valid <= 1'b0;
        end else begin
            if (c_en) r_f_valid <= i_valid;
            r_h_valid <= n_h_valid;
            r_s_valid <= n_s_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_en) r_f <= c_res;
        r_h <= n_h;
        r_s <= n_s;
    end

    assign o_en     = c_en;
    assign o_valid  = r_h_valid;
    assign o_vx     = r_h.vx;
    assign o_vy     = r_h.vy;
    assign o_damped = r_h.damped;

endmodule

// ----- test/mpevd_velocity_checker.sv -----
// ----------------------------------------------------------------------------
// mpevd_velocity_checker
// Watches the point and velocity streams, predicts each velocity word and
// compares it field by field with what the damper returns.
// ----------------------------------------------------------------------------
module mpevd_velocity_checker import mpevd_pkg::*; #(
    parameter int INDEX_BITS = INDEX_BITS_DEF,
    parameter int IN_W       = ((INDEX_BITS + 6 * DATA_W + 7) / 8) * 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [IDX_W-1:0]    i_cfg_index,
    input  logic [DATA_W-1:0]   i_cfg_data,
    input  logic                i_in_valid,
    input  logic                i_in_ready,
    input  logic [IN_W-1:0]     i_in_data,
    input  logic                i_out_valid,
    input  logic                i_out_ready,
    input  logic [2*DATA_W-1:0] i_out_data,
    input  logic [0:0]          i_out_user,
    output int                  o_errors,
    output int                  o_pending,
    output int                  o_damped_seen,
    output int                  o_words_seen
);

    typedef struct {
        logic signed [31:0] vx;
        logic signed [31:0] vy;
        logic               damped;
    } t_velocity;

    t_velocity         expected_q[$];
    logic [30:0]       outer_r, r1, r2;
    logic signed [31:0] c1x, c1y, c2x, c2y;
    logic [16:0]       special_cnt;

    assign o_pending = expected_q.size();

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        o_errors++;
    endtask

    function automatic longint sat32(input logic signed [127:0] v);
        if (v > 128'sd2147483647) return 64'sd2147483647;
        if (v < -128'sd2147483648) return -64'sd2147483648;
        return longint'(v);
    endfunction

    function automatic logic circle_hit(input logic signed [63:0] dx, input logic signed [63:0] dy,
                                        input logic [30:0] r);
        logic signed [127:0] d2, rr;
        d2 = dx * dx + dy * dy;
        rr = $signed({97'd0, r}) * $signed({97'd0, r});
        return d2 < rr;
    endfunction

    function automatic t_velocity predict_velocity(input logic [IN_W-1:0] d);
        t_velocity           res;
        logic [INDEX_BITS-1:0] idx;
        logic signed [63:0]  x, y, vx, vy, bx, by, dx, dy;
        logic signed [127:0] n, s, ro, cx, cy, den;
        logic                dec;
        idx = d[INDEX_BITS-1:0];
        x  = $signed(d[INDEX_BITS +: 32]);
        y  = $signed(d[INDEX_BITS+32 +: 32]);
        vx = $signed(d[INDEX_BITS+64 +: 32]);
        vy = $signed(d[INDEX_BITS+96 +: 32]);
        bx = $signed(d[INDEX_BITS+128 +: 32]);
        by = $signed(d[INDEX_BITS+160 +: 32]);
        res.damped = 1'b0;
        if ({1'b0, idx} < {1'b0, special_cnt}) begin
            res.vx = 0;
            res.vy = 0;
            return res;
        end
        n  = 128'(x) * x + 128'(y) * y;
        ro = $signed({97'd0, outer_r}) * $signed({97'd0, outer_r});
        dec = 1'b0;
        if (n > ro) begin
            dec = (128'(x) * vx + 128'(y) * vy) > 0;
        end else begin
            dx = x - c1x;
            dy = y - c1y;
            if (circle_hit(dx, dy, r1)) begin
                dec = (128'(dx) * vx + 128'(dy) * vy) < 0;
            end else begin
                dx = x - c2x;
                dy = y - c2y;
                if (circle_hit(dx, dy, r2))
                    dec = (128'(dx) * vx + 128'(dy) * vy) < 0;
            end
        end
        res.vx = 32'(bx);
        res.vy = 32'(by);
        if (dec) begin
            res.damped = 1'b1;
            res.vx = 32'(vx);
            res.vy = 32'(vy);
            if (n != 0) begin
                // 192-bit products avoid overflow of 9*s*p
                s   = 128'(x) * vx + 128'(y) * vy;
                den = n * 10;
                cx  = 128'((192'(s) * 9 * 192'(x)) / 192'(den));
                cy  = 128'((192'(s) * 9 * 192'(y)) / 192'(den));
                res.vx = 32'(sat32(128'(vx) - cx));
                res.vy = 32'(sat32(128'(vy) - cy));
            end
        end
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_velocity want;
        if (!i_rst_n) begin
            outer_r <= '0; r1 <= '0; r2 <= '0;
            c1x <= '0; c1y <= '0; c2x <= '0; c2y <= '0;
            special_cnt <= '0;
        end else begin
            if (i_cfg_we) begin
                case (t_reg_idx'(i_cfg_index))
                    REG_OUTER_RADIUS:  outer_r     <= i_cfg_data[30:0];
                    REG_FIRST_RADIUS:  r1          <= i_cfg_data[30:0];
                    REG_FIRST_CX:      c1x         <= i_cfg_data;
                    REG_FIRST_CY:      c1y         <= i_cfg_data;
                    REG_SECOND_RADIUS: r2          <= i_cfg_data[30:0];
                    REG_SECOND_CX:     c2x         <= i_cfg_data;
                    REG_SECOND_CY:     c2y         <= i_cfg_data;
                    REG_SPECIAL_COUNT: special_cnt <= i_cfg_data[16:0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready)
                expected_q.push_back(predict_velocity(i_in_data));
            if (i_out_valid && i_out_ready) begin
                o_words_seen++;
                if (expected_q.size() == 0) begin
                    report_mismatch("unexpected word", 0, 0);
                end else begin
                    want = expected_q.pop_front();
                    if (i_out_user[0]) o_damped_seen++;
                    if ($signed(i_out_data[31:0]) != want.vx)
                        report_mismatch("out_vx", $signed(i_out_data[31:0]), want.vx);
                    if ($signed(i_out_data[63:32]) != want.vy)
                        report_mismatch("out_vy", $signed(i_out_data[63:32]), want.vy);
                    if (i_out_user[0] != want.damped)
                        report_mismatch("damped", i_out_user[0], want.damped);
                end
            end
        end
    end

    initial begin
        o_errors = 0;
        o_damped_seen = 0;
        o_words_seen = 0;
    end

endmodule

// ----- test/tb_mesh_point_edge_velocity_damper.sv -----
// ----------------------------------------------------------------------------
// tb_mesh_point_edge_velocity_damper
// Drives mesh points through the damper under random stalls on both streams,
// with several circle and special-count setups; a checker predicts each word.
// ----------------------------------------------------------------------------
module tb_mesh_point_edge_velocity_damper;
    import mpevd_pkg::*;

    localparam int INDEX_BITS = INDEX_BITS_DEF;
    localparam int IN_W       = ((INDEX_BITS + 6 * DATA_W + 7) / 8) * 8;
    localparam int LATENCY    = 60;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                cfg_we = 1'b0;
    logic [IDX_W-1:0]    cfg_index = '0;
    logic [DATA_W-1:0]   cfg_data = '0;
    logic                in_valid = 1'b0;
    logic                in_ready;
    logic [IN_W-1:0]     in_data = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    logic [2*DATA_W-1:0] out_data;
    logic [0:0]          out_user;
    int                  errors, pending, damped_seen, words_seen;
    int                  points_sent = 0;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    mesh_point_edge_velocity_damper #(.INDEX_BITS(INDEX_BITS)) u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(cfg_we), .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .s_axis_tvalid(in_valid), .s_axis_tready(in_ready), .s_axis_tdata(in_data),
        .m_axis_tvalid(out_valid), .m_axis_tready(out_ready),
        .m_axis_tdata(out_data), .m_axis_tuser(out_user)
    );

    mpevd_velocity_checker #(.INDEX_BITS(INDEX_BITS)) u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(cfg_we), .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .i_in_valid(in_valid), .i_in_ready(in_ready), .i_in_data(in_data),
        .i_out_valid(out_valid), .i_out_ready(out_ready),
        .i_out_data(out_data), .i_out_user(out_user),
        .o_errors(errors), .o_pending(pending),
        .o_damped_seen(damped_seen), .o_words_seen(words_seen)
    );

    // receiver: random stall per word, with stall-free stretches
    initial begin
        int gap;
        forever begin
            @(negedge i_clk);
            out_ready <= 1'b1;
            @(posedge i_clk);
            while (!out_valid) @(posedge i_clk);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
            if (gap > 0) begin
                @(negedge i_clk);
                out_ready <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
    end

    task automatic write_reg(input t_reg_idx idx, input logic [31:0] value);
        @(negedge i_clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge i_clk);
        cfg_we <= 1'b0;
    endtask

    task automatic drain_points();
        @(negedge i_clk);
        in_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (LATENCY) @(negedge i_clk);
    endtask

    // leaves valid high after the accepting edge so words can follow back to back
    task automatic send_point(input logic [15:0] idx,
                              input logic [31:0] x, input logic [31:0] y,
                              input logic [31:0] vx, input logic [31:0] vy,
                              input logic [31:0] bx, input logic [31:0] by,
                              input int gap);
        if (gap > 0) begin
            @(negedge i_clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        in_valid <= 1'b1;
        in_data  <= IN_W'({by, bx, vy, vx, y, x, idx});
        @(posedge i_clk);
        while (!in_ready) @(posedge i_clk);
        points_sent++;
    endtask

    function automatic logic [31:0] rand_coord(input logic [31:0] span);
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
            default: return $urandom_range(0, 2 * span) - span;
        endcase
    endfunction

    // one setup: circles placed near the origin with radii of a given scale
    task automatic load_setup(input logic [31:0] scale, input logic [16:0] special);
        write_reg(REG_OUTER_RADIUS, scale);
        write_reg(REG_FIRST_RADIUS, scale >> 2);
        write_reg(REG_FIRST_CX, scale >> 1);
        write_reg(REG_FIRST_CY, -(scale >> 2));
        write_reg(REG_SECOND_RADIUS, scale / 5);
        write_reg(REG_SECOND_CX, -(scale >> 1));
        write_reg(REG_SECOND_CY, scale >> 2);
        write_reg(REG_SPECIAL_COUNT, 32'(special));
    endtask

    task automatic random_points(input int count, input logic [31:0] span, input logic [16:0] spec);
        int gap;
        for (int i = 0; i < count; i++) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
            send_point(($urandom_range(0, 7) == 0) ? 16'($urandom_range(0, spec)) : 16'($urandom),
                       rand_coord(span), rand_coord(span),
                       rand_coord(span), rand_coord(span), $urandom(), $urandom(), gap);
        end
    endtask

    initial begin
        logic [31:0] spans [4];
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: all-zero registers, then a small layout
        send_point(16'd0, 32'd0, 32'd0, 32'd5, 32'd7, 32'd11, 32'd13, 0);
        send_point(16'hffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                   32'h1, 32'h2, 0);
        send_point(16'hffff, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
                   32'h3, 32'h4, 0);
        send_point(16'h1234, 32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h80000000,
                   32'hffffffff, 32'h80000000, 0);
        drain_points();
        load_setup(32'h0010_0000, 17'd4);
        send_point(16'd3, 32'h0020_0000, 32'd0, 32'h0001_0000, 32'd0, 32'd9, 32'd9, 0);
        send_point(16'd4, 32'h0020_0000, 32'd0, 32'h0001_0000, 32'd0, 32'd9, 32'd9, 0);
        send_point(16'd4, 32'h0020_0000, 32'd0, 32'hffff_0000, 32'd0, 32'd9, 32'd9, 0);
        // inside first circle moving toward and away from its center
        send_point(16'd9, 32'h0009_0000, 32'hfffc_0000, 32'hffff_0000, 32'd0, 32'd1, 32'd1, 1);
        send_point(16'd9, 32'h0009_0000, 32'hfffc_0000, 32'h0001_0000, 32'd0, 32'd1, 32'd1, 1);
        // inside second circle
        send_point(16'd9, 32'hfff7_0000, 32'h0004_0000, 32'h0001_0000, 32'd0, 32'd1, 32'd1, 2);
        // exactly on the outer radius: not outside
        send_point(16'd9, 32'h0010_0000, 32'd0, 32'h0001_0000, 32'd0, 32'd7, 32'd7, 0);
        // outer radius at its maximum, special count above every 16-bit index
        drain_points();
        load_setup(32'h7fffffff, 17'h10000);
        send_point(16'hffff, 32'd5, 32'd5, 32'd1, 32'd1, 32'd2, 32'd2, 0);
        drain_points();
        write_reg(REG_SPECIAL_COUNT, 32'd0);
        // origin lying inside a circle gets the cell velocity unchanged
        write_reg(REG_FIRST_CX, 32'h0000_0001);
        write_reg(REG_FIRST_CY, 32'h0000_0000);
        send_point(16'd0, 32'd0, 32'd0, 32'h0005_0000, 32'h0003_0000, 32'd1, 32'd1, 0);
        send_point(16'd1, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff,
                   32'd1, 32'd1, 0);

        spans[0] = 32'h0000_4000;
        spans[1] = 32'h0010_0000;
        spans[2] = 32'h4000_0000;
        spans[3] = 32'h7fff_ffff;
        for (int ph = 0; ph < 8; ph++) begin
            drain_points();
            load_setup(spans[ph % 4] >> ($urandom_range(0, 1)),
                       (ph == 7) ? 17'h1ffff : 17'($urandom_range(0, 300)));
            random_points(215, spans[ph % 4], 17'd300);
        end
        drain_points();
        $display("points sent %0d, words checked %0d, damped %0d, over eight setups",
                 points_sent, words_seen, damped_seen);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        #12_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
